FILE: rtl/weekly_alarm_next_offset_unit_macros.svh
// assertion macros shared by the weekly alarm checker
`ifndef WEEKLY_ALARM_NEXT_OFFSET_UNIT_MACROS_SVH
`define WEEKLY_ALARM_NEXT_OFFSET_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define WANO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("weekly alarm port check failed");

// condition must never hold
`define WANO_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("weekly alarm port check failed");

`endif

FILE: rtl/wano_pkg.sv
// types and constants of the weekly alarm next offset unit
package wano_pkg;

	localparam int DAY_MINUTES  = 1440;
	localparam int HOUR_MINUTES = 60;
	localparam int WEEK_DAYS    = 7;
	localparam int MAX_OFFSET   = 10080;

	localparam int OFF_W = 14;

	typedef enum logic [2:0] {
		REG_FIRST_ENABLE   = 3'd0,
		REG_FIRST_HOUR     = 3'd1,
		REG_FIRST_MINUTE   = 3'd2,
		REG_FIRST_DAYS     = 3'd3,
		REG_SECOND_ENABLE  = 3'd4,
		REG_SECOND_HOUR    = 3'd5,
		REG_SECOND_MINUTE  = 3'd6,
		REG_SECOND_DAYS    = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
		logic       match_now;
		logic       switch_on;
	} query_t;

	typedef struct packed {
		logic             found;
		logic             which_alarm;
		logic [OFF_W-1:0] minutes_until;
		logic             due;
	} result_t;

	typedef struct packed {
		logic       enable;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [6:0] days;
	} alarm_cfg_t;

	typedef struct packed {
		logic             act;
		logic [OFF_W-1:0] off;
	} alarm_res_t;

endpackage

FILE: rtl/wano_offset_pipe.sv
// two pipeline stages computing one alarm's offset in minutes
module wano_offset_pipe
	import wano_pkg::*;
(
	input  logic       clk,
	input  alarm_cfg_t cfg,
	input  query_t     query,
	output alarm_res_t res
);

	// stage 1 signals
	logic [2:0]        wd_norm;
	logic [2:0]        wd_base;
	logic [3:0]        rot_idx [WEEK_DAYS];
	logic [6:0]        rot;
	logic              ahead;
	logic              same_min;
	logic signed [5:0] hour_diff;
	logic signed [6:0] min_diff;
	logic signed [14:0] tdiff;

	logic               act_s1;
	logic               today_ok_s1;
	logic [6:1]         later_s1;
	logic signed [14:0] tdiff_s1;

	// stage 2 signals
	logic [2:0]         day_k;
	logic [OFF_W-1:0]   day_off;
	logic signed [14:0] off_sum;
	logic [OFF_W-1:0]   off_clamp;

	logic               act_s2;
	logic [OFF_W-1:0]   off_s2;

	// rotate the day mask so bit 0 is today, weekday zero reads as seven
	always_comb begin
		wd_norm = (query.weekday == 3'd0) ? 3'd7 : query.weekday;
		wd_base = wd_norm - 3'd1;
		for (int i = 0; i < WEEK_DAYS; i++) begin
			rot_idx[i] = {1'b0, wd_base} + 4'(i);
			if (rot_idx[i] >= 4'(WEEK_DAYS)) begin
				rot_idx[i] = rot_idx[i] - 4'(WEEK_DAYS);
			end
			rot[i] = cfg.days[rot_idx[i][2:0]];
		end
	end

	// time of day compare and signed time difference
	always_comb begin
		same_min  = (cfg.hour == query.now_hour) && (cfg.minute == query.now_minute);
		ahead     = (cfg.hour > query.now_hour) ||
			((cfg.hour == query.now_hour) && (cfg.minute > query.now_minute));
		hour_diff = $signed({1'b0, cfg.hour} - {1'b0, query.now_hour});
		min_diff  = $signed({1'b0, cfg.minute} - {1'b0, query.now_minute});
		tdiff     = 15'(hour_diff) * 15'(HOUR_MINUTES) + 15'(min_diff);
	end

	always_ff @(posedge clk) begin
		act_s1      <= query.switch_on && cfg.enable && (cfg.days != 7'd0);
		today_ok_s1 <= rot[0] && (ahead || (query.match_now && same_min));
		later_s1    <= rot[6:1];
		tdiff_s1    <= tdiff;
	end

	// first selected day ahead, a full week when none
	always_comb begin
		day_k = 3'd7;
		for (int i = 6; i >= 1; i--) begin
			if (later_s1[i]) begin
				day_k = 3'(i);
			end
		end
		if (today_ok_s1) begin
			day_k = 3'd0;
		end
		day_off = 14'({11'd0, day_k} * 14'(DAY_MINUTES));
		off_sum = $signed({1'b0, day_off}) + tdiff_s1;
		if (off_sum < 15'sd0) begin
			off_clamp = '0;
		end else if (off_sum > 15'(MAX_OFFSET)) begin
			off_clamp = 14'(MAX_OFFSET);
		end else begin
			off_clamp = off_sum[OFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		act_s2 <= act_s1;
		off_s2 <= off_clamp;
	end

	assign res.act = act_s2;
	assign res.off = off_s2;

endmodule

FILE: rtl/wano_select.sv
// output stage picking the sooner of the two alarms
module wano_select
	import wano_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  alarm_res_t res0,
	input  alarm_res_t res1,
	output logic       valid_s3,
	output result_t    result_s3
);

	result_t pick;

	// ties go to alarm 0, nothing found gives all zero
	always_comb begin
		pick = '0;
		if (res0.act && res1.act) begin
			pick.found = 1'b1;
			if (res1.off < res0.off) begin
				pick.which_alarm   = 1'b1;
				pick.minutes_until = res1.off;
			end else begin
				pick.minutes_until = res0.off;
			end
		end else if (res0.act) begin
			pick.found         = 1'b1;
			pick.minutes_until = res0.off;
		end else if (res1.act) begin
			pick.found         = 1'b1;
			pick.which_alarm   = 1'b1;
			pick.minutes_until = res1.off;
		end
		pick.due = pick.found && (pick.minutes_until == '0);
	end

	// strobe for the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= pick;
	end

endmodule

FILE: rtl/weekly_alarm_next_offset_unit.sv
// top level of the weekly alarm next offset unit
// Usage:
//   A query (weekday, hour, minute, match flag, master switch) is taken at a
//   rising edge with start high and busy low. busy stays low: the unit takes
//   a query in every cycle.
//   Each query yields one result (found, which alarm, minutes until, due),
//   shown on result for a single cycle with result_valid high. The receiver
//   cannot hold it off, and it needs not: results leave at the input rate.
//   The stages in order: the day mask rotation and time difference stage,
//   the day search and offset clamp stage, then the alarm pick stage that
//   drives the output register.
//   Throughput is one query per cycle: every stage advances on each clock
//   and no stage feeds back into an earlier one.
//   The two alarms are set through cfg_we, cfg_index, cfg_data, one register
//   per write, taken at once; write them only while no query is in flight.
//   Reset clears all alarm settings and the stage valid bits; no query is
//   lost or repeated since no stage ever stalls.
module weekly_alarm_next_offset_unit
	import wano_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  query_t     query,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output result_t    result
);

	alarm_cfg_t alarm0_q;
	alarm_cfg_t alarm1_q;
	alarm_res_t res0;
	alarm_res_t res1;
	logic       valid_s1;
	logic       valid_s2;

	// the pipeline never stalls
	assign busy = 1'b0;

	// alarm setting registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm0_q <= '0;
			alarm1_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_FIRST_ENABLE:  alarm0_q.enable <= cfg_data[0];
				REG_FIRST_HOUR:    alarm0_q.hour   <= cfg_data[4:0];
				REG_FIRST_MINUTE:  alarm0_q.minute <= cfg_data[5:0];
				REG_FIRST_DAYS:    alarm0_q.days   <= cfg_data;
				REG_SECOND_ENABLE: alarm1_q.enable <= cfg_data[0];
				REG_SECOND_HOUR:   alarm1_q.hour   <= cfg_data[4:0];
				REG_SECOND_MINUTE: alarm1_q.minute <= cfg_data[5:0];
				REG_SECOND_DAYS:   alarm1_q.days   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits alongside the offset stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	wano_offset_pipe u_pipe0 (
		.clk   (clk),
		.cfg   (alarm0_q),
		.query (query),
		.res   (res0)
	);

	wano_offset_pipe u_pipe1 (
		.clk   (clk),
		.cfg   (alarm1_q),
		.query (query),
		.res   (res1)
	);

	wano_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.res0      (res0),
		.res1      (res1),
		.valid_s3  (result_valid),
		.result_s3 (result)
	);

endmodule

FILE: rtl/wano_checker.sv
// port level checker for the weekly alarm next offset unit and its bind
`include "weekly_alarm_next_offset_unit_macros.svh"

module wano_checker
	import wano_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	// a result only follows a query taken through both offset stages and the output register
	`WANO_ASSERT_IMP(a_result_has_query, clk, arst_n, result_valid, $past(start && !busy, 3))

	// due only with a zero offset of a found alarm
	`WANO_ASSERT_IMP(a_due_zero, clk, arst_n, result_valid && result.due, result.found && (result.minutes_until == '0))

	// nothing found leaves the other fields clear
	`WANO_ASSERT_IMP(a_none_clear, clk, arst_n, result_valid && !result.found, !result.which_alarm && !result.due && (result.minutes_until == '0))

	// offset never beyond one week
	`WANO_ASSERT_NEVER(a_offset_range, clk, arst_n, result_valid && (result.minutes_until > 14'(MAX_OFFSET)))

endmodule

bind weekly_alarm_next_offset_unit wano_checker u_wano_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
